[design/jts_pkg.sv]
// ----------------------------------------------------------------------------
// jts_pkg
// shared types and constants for the json token serializer
// ----------------------------------------------------------------------------
`default_nettype none

package jts_pkg;

	localparam int STACK_DEPTH_DEF = 32;
	localparam int MAX_RUN         = 6;
	localparam int RUN_W           = 3;

	typedef enum logic [3:0] {
		CMD_ARR_OPEN  = 4'd0,
		CMD_ARR_CLOSE = 4'd1,
		CMD_OBJ_OPEN  = 4'd2,
		CMD_OBJ_CLOSE = 4'd3,
		CMD_STR_CHAR  = 4'd4,
		CMD_NUM_CHAR  = 4'd5,
		CMD_TRUE      = 4'd6,
		CMD_FALSE     = 4'd7,
		CMD_NULL      = 4'd8
	} cmd_t;

	// one nesting frame: kind plus parity and nonzero state of its element count
	typedef struct packed {
		logic nonzero;
		logic odd;
		logic is_obj;
	} frame_t;

	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BSLASH    = 8'h5C;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_COMMA     = 8'h2C;
	localparam logic [7:0] CH_COLON     = 8'h3A;
	localparam logic [7:0] CH_LBRACKET  = 8'h5B;
	localparam logic [7:0] CH_RBRACKET  = 8'h5D;
	localparam logic [7:0] CH_LBRACE    = 8'h7B;
	localparam logic [7:0] CH_RBRACE    = 8'h7D;
	localparam logic [7:0] CH_N         = 8'h6E;
	localparam logic [7:0] CH_T         = 8'h74;
	localparam logic [7:0] CH_NUL       = 8'h00;

	localparam logic [7:0] TXT_TRUE  [0:3] = '{8'h74, 8'h72, 8'h75, 8'h65};
	localparam logic [7:0] TXT_FALSE [0:4] = '{8'h66, 8'h61, 8'h6C, 8'h73, 8'h65};
	localparam logic [7:0] TXT_NULL  [0:3] = '{8'h6E, 8'h75, 8'h6C, 8'h6C};

endpackage

`default_nettype wire

[design/jts_ram.sv]
// ----------------------------------------------------------------------------
// jts_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module jts_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

[design/json_token_serializer.sv]
// ----------------------------------------------------------------------------
// json_token_serializer
// turns a stream of json tokens into json text, one byte per output request
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  in       | in_valid / in_ready  | cmd, data_char, is_first, is_last,
//           |                      | has_char
//  out      | out_valid / out_ready| out_char, last_of_run, overflow_error
//
//  a request sits in the decode register, where the top frame and the frame
//  below it (ram read issued the cycle before) set its bytes and the next
//  stack state; the output buffer then sends one byte a cycle while out_ready
//  is high. a request produces 1 to 6 bytes, or none.
//  the top frame lives in a register, the frames below it in the stack ram;
//  a push writes the old top to the ram address that is read in that cycle,
//  and a forward register covers that read.
//  reset clears the level, decode and output valids; the ram needs no clearing.
//  a stalled output keeps one more request in the decode register.
// ----------------------------------------------------------------------------
`default_nettype none

module json_token_serializer #(
	parameter int STACK_DEPTH = jts_pkg::STACK_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [3:0] cmd,
	input  wire logic [7:0] data_char,
	input  wire logic       is_first,
	input  wire logic       is_last,
	input  wire logic       has_char,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic      [7:0] out_char,
	output logic            last_of_run,
	output logic            overflow_error
);

	import jts_pkg::*;

	localparam int LW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	// decode register
	logic       s1_valid;
	logic [3:0] cmd_s1;
	logic [7:0] data_s1;
	logic       first_s1;
	logic       last_s1;
	logic       has_s1;
	logic       s1_move;

	// stack state
	logic [LW-1:0] level_q;
	frame_t        top_q;
	frame_t        fwd_d_q;
	logic          fwd_v_q;
	frame_t        ram_rd;
	frame_t        below;

	// output buffer
	logic [7:0]       ob_chars_q [0:MAX_RUN-1];
	logic [RUN_W-1:0] ob_cnt_q;
	logic [RUN_W-1:0] ob_idx_q;
	logic             ob_ovf_q;
	logic             ob_valid_q;
	logic             ob_last;
	logic             ob_free;

	// decode results
	logic [7:0]       chars [0:MAX_RUN-1];
	logic [RUN_W-1:0] n;
	logic             ovf;
	logic [LW-1:0]    lvl_d;
	frame_t           top_d;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [AW-1:0]    rd_addr;
	logic [LW:0]      lvl_eff;
	logic [LW:0]      wr_tmp;
	logic [LW:0]      rd_tmp;
	logic             sep_ok;
	logic [7:0]       sep_char;
	frame_t           counted;
	frame_t           below_counted;

	assign ob_last  = ob_idx_q == (ob_cnt_q - RUN_W'(1));
	assign ob_free  = !ob_valid_q || (out_ready && ob_last);
	assign s1_move  = s1_valid && ob_free;
	assign in_ready = !s1_valid || s1_move;

	assign out_valid      = ob_valid_q;
	assign out_char       = ob_chars_q[ob_idx_q];
	assign last_of_run    = ob_last;
	assign overflow_error = ob_ovf_q;

	assign below = fwd_v_q ? fwd_d_q : ram_rd;

	always_comb begin
		sep_ok        = (level_q != '0) && top_q.nonzero;
		sep_char      = (top_q.is_obj && top_q.odd) ? CH_COLON : CH_COMMA;
		counted       = '{nonzero: 1'b1, odd: ~top_q.odd, is_obj: top_q.is_obj};
		below_counted = '{nonzero: 1'b1, odd: ~below.odd, is_obj: below.is_obj};
		for (int i = 0; i < MAX_RUN; i++) begin
			chars[i] = CH_NUL;
		end
		n     = '0;
		ovf   = 1'b0;
		lvl_d = level_q;
		top_d = top_q;
		wr_en = 1'b0;
		case (cmd_t'(cmd_s1))
			CMD_ARR_OPEN, CMD_OBJ_OPEN: begin
				if ({1'b0, level_q} >= (LW+1)'(STACK_DEPTH)) begin
					chars[0] = CH_NUL;
					n        = RUN_W'(1);
					ovf      = 1'b1;
				end else begin
					if (sep_ok) begin
						chars[n] = sep_char;
						n        = n + RUN_W'(1);
					end
					chars[n] = (cmd_t'(cmd_s1) == CMD_OBJ_OPEN) ? CH_LBRACE : CH_LBRACKET;
					n        = n + RUN_W'(1);
					top_d    = '{nonzero: 1'b0, odd: 1'b0,
						is_obj: cmd_t'(cmd_s1) == CMD_OBJ_OPEN};
					lvl_d    = level_q + LW'(1);
					// old top goes down into the ram
					wr_en    = level_q != '0;
				end
			end
			CMD_ARR_CLOSE, CMD_OBJ_CLOSE: begin
				chars[0] = (cmd_t'(cmd_s1) == CMD_OBJ_CLOSE) ? CH_RBRACE : CH_RBRACKET;
				n        = RUN_W'(1);
				if (level_q != '0) begin
					lvl_d = level_q - LW'(1);
					top_d = (level_q > LW'(1)) ? below_counted : below;
				end
			end
			CMD_STR_CHAR, CMD_NUM_CHAR: begin
				if (first_s1) begin
					if (sep_ok) begin
						chars[n] = sep_char;
						n        = n + RUN_W'(1);
					end
					chars[n] = CH_QUOTE;
					n        = n + RUN_W'(1);
				end
				if (has_s1) begin
					if (data_s1 == CH_QUOTE || data_s1 == CH_NEWLINE || data_s1 == CH_TAB) begin
						chars[n] = CH_BSLASH;
						n        = n + RUN_W'(1);
						chars[n] = (data_s1 == CH_QUOTE) ? CH_QUOTE :
							(data_s1 == CH_NEWLINE) ? CH_N : CH_T;
					end else begin
						chars[n] = data_s1;
					end
					n = n + RUN_W'(1);
				end
				if (last_s1) begin
					chars[n] = CH_QUOTE;
					n        = n + RUN_W'(1);
					if (level_q != '0) begin
						top_d = counted;
					end
				end
			end
			CMD_TRUE, CMD_NULL: begin
				if (sep_ok) begin
					chars[n] = sep_char;
					n        = n + RUN_W'(1);
				end
				for (int i = 0; i < 4; i++) begin
					chars[n] = (cmd_t'(cmd_s1) == CMD_TRUE) ? TXT_TRUE[i] : TXT_NULL[i];
					n        = n + RUN_W'(1);
				end
				if (level_q != '0) begin
					top_d = counted;
				end
			end
			CMD_FALSE: begin
				if (sep_ok) begin
					chars[n] = sep_char;
					n        = n + RUN_W'(1);
				end
				for (int i = 0; i < 5; i++) begin
					chars[n] = TXT_FALSE[i];
					n        = n + RUN_W'(1);
				end
				if (level_q != '0) begin
					top_d = counted;
				end
			end
			default: begin
				n = '0;
			end
		endcase
	end

	// ram keeps frames below the top; always read the one under the next top
	always_comb begin
		lvl_eff = {1'b0, (s1_move ? lvl_d : level_q)};
		rd_tmp  = lvl_eff - (LW+1)'(2);
		wr_tmp  = {1'b0, level_q} - (LW+1)'(1);
		rd_addr = rd_tmp[AW-1:0];
		wr_addr = wr_tmp[AW-1:0];
	end

	jts_ram #(
		.WIDTH ($bits(frame_t)),
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_stack (
		.clk     (clk),
		.wr_en   (s1_move && wr_en),
		.wr_addr (wr_addr),
		.wr_data (top_q),
		.rd_addr (rd_addr),
		.rd_data (ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid   <= 1'b0;
			level_q    <= '0;
			fwd_v_q    <= 1'b0;
			ob_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				s1_valid <= in_valid;
			end
			fwd_v_q <= s1_move && wr_en && (wr_addr == rd_addr);
			if (s1_move) begin
				level_q <= lvl_d;
			end
			if (out_valid && out_ready && ob_last) begin
				ob_valid_q <= 1'b0;
			end
			if (s1_move && n != '0) begin
				ob_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1   <= cmd;
			data_s1  <= data_char;
			first_s1 <= is_first;
			last_s1  <= is_last;
			has_s1   <= has_char;
		end
		fwd_d_q <= top_q;
		if (s1_move) begin
			top_q <= top_d;
		end
		if (out_valid && out_ready && !ob_last) begin
			ob_idx_q <= ob_idx_q + RUN_W'(1);
		end
		if (s1_move && n != '0) begin
			ob_chars_q <= chars;
			ob_cnt_q   <= n;
			ob_idx_q   <= '0;
			ob_ovf_q   <= ovf;
		end
	end

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, level_q} <= (LW+1)'(STACK_DEPTH))
		else $error("nesting level beyond stack depth");

	a_ovf_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow_error |-> last_of_run && out_char == CH_NUL)
		else $error("overflow request not a single zero byte");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		ob_valid_q |-> ob_idx_q < ob_cnt_q)
		else $error("output index past byte count");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !s1_move |=> s1_valid && $stable(cmd_s1))
		else $error("stalled request lost from decode register");

endmodule

`default_nettype wire
